// ----- hw/rtl/f2qp_pkg.sv -----
package f2qp_pkg;

  localparam int W  = 16;             // field width
  localparam int F  = W - 2;          // fraction bits
  localparam int PW = 2 * W;          // product width
  localparam int CW = W + 3;          // cross product width after rounding
  localparam int AW = CW + 1;         // root argument width, signed
  localparam int DW = CW + 1;         // numerator difference width, signed
  localparam int XW = AW - 1 + F - 2; // root operand width
  localparam int QN = (XW + 1) / 2;   // root bits, one per stage
  localparam int SW = 2 * QN + 1;     // root remainder width
  localparam int QW = QN + 1;         // rounded root width
  localparam int VW = QW + 2;         // divisor width
  localparam int NW = DW + F + 1;     // dividend width
  localparam int EW = NW + W;         // compare width in the divider

  localparam logic signed [W-1:0] FLD_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] FLD_MIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [1:0] {
    SEL_W = 2'd0,
    SEL_X = 2'd1,
    SEL_Y = 2'd2,
    SEL_Z = 2'd3
  } sel_e;

  typedef struct packed {
    logic signed [AW-1:0] arg;
    sel_e                 sel;
    logic [3:0][DW-1:0]   d;
  } conv_in_t;

  typedef struct packed {
    logic               ok;
    sel_e               sel;
    logic [3:0][DW-1:0] d;
  } side_t;

  typedef struct packed {
    logic              ok;
    logic [3:0][W-1:0] q;
  } conv_out_t;

  function automatic conv_in_t mk_conv(
    input logic signed [CW-1:0] m00, input logic signed [CW-1:0] m01,
    input logic signed [CW-1:0] m02, input logic signed [CW-1:0] m10,
    input logic signed [CW-1:0] m11, input logic signed [CW-1:0] m12,
    input logic signed [CW-1:0] m20, input logic signed [CW-1:0] m21,
    input logic signed [CW-1:0] m22);
    logic signed [AW-1:0] one;
    logic signed [AW-1:0] tr;
    logic signed [DW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    conv_in_t r;
    one = AW'(1) <<< F;
    e00 = DW'(m00); e01 = DW'(m01); e02 = DW'(m02);
    e10 = DW'(m10); e11 = DW'(m11); e12 = DW'(m12);
    e20 = DW'(m20); e21 = DW'(m21); e22 = DW'(m22);
    tr = AW'(e00) + AW'(e11) + AW'(e22);
    r.d = '0;
    if (tr > 0) begin
      r.sel  = SEL_W;
      r.arg  = tr + one;
      r.d[1] = e21 - e12;
      r.d[2] = e02 - e20;
      r.d[3] = e10 - e01;
    end else if (m00 > m11 && m00 > m22) begin
      r.sel  = SEL_X;
      r.arg  = one + AW'(e00) - AW'(e11) - AW'(e22);
      r.d[0] = e21 - e12;
      r.d[2] = e01 + e10;
      r.d[3] = e02 + e20;
    end else if (m11 > m22) begin
      r.sel  = SEL_Y;
      r.arg  = one + AW'(e11) - AW'(e00) - AW'(e22);
      r.d[0] = e02 - e20;
      r.d[1] = e01 + e10;
      r.d[3] = e12 + e21;
    end else begin
      r.sel  = SEL_Z;
      r.arg  = one + AW'(e22) - AW'(e00) - AW'(e11);
      r.d[0] = e10 - e01;
      r.d[1] = e02 + e20;
      r.d[2] = e12 + e21;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/f2qp_conv.sv -----
module f2qp_conv (
  input  logic                clk_i,
  input  logic                en_i,
  input  f2qp_pkg::conv_in_t  conv_i,
  output f2qp_pkg::conv_out_t conv_o
);
  import f2qp_pkg::*;

  logic [SW-1:0] sq_rem_q  [QN];
  logic [QN-1:0] sq_root_q [QN];
  side_t         sq_side_q [QN];
  side_t         side0;
  logic [SW-1:0] x0;

  assign side0.ok  = (conv_i.arg > 0);
  assign side0.sel = conv_i.sel;
  assign side0.d   = conv_i.d;
  assign x0 = SW'({conv_i.arg[AW-2:0], {(F-2){1'b0}}});

  // square root, one result bit per stage
  for (genvar k = 0; k < QN; k++) begin : g_sqrt
    localparam int B = QN - 1 - k;
    logic [SW-1:0] rem_in, t;
    logic [QN-1:0] root_in;
    side_t         side_in;
    if (k == 0) begin : g_first
      assign rem_in  = x0;
      assign root_in = '0;
      assign side_in = side0;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign side_in = sq_side_q[k-1];
    end
    assign t = (SW'(root_in) << (B + 1)) | (SW'(1) << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_side_q[k] <= side_in;
        if (rem_in >= t) begin
          sq_rem_q[k]  <= rem_in - t;
          sq_root_q[k] <= root_in | (QN'(1) << B);
        end else begin
          sq_rem_q[k]  <= rem_in;
          sq_root_q[k] <= root_in;
        end
      end
    end
  end

  // round to nearest
  logic [QW-1:0] rq_q;
  side_t         rs_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rs_q <= sq_side_q[QN-1];
      rq_q <= QW'(sq_root_q[QN-1])
            + QW'(sq_rem_q[QN-1] > SW'(sq_root_q[QN-1]));
    end
  end

  // dividend, divisor and overflow per lane
  logic [3:0][NW-1:0] dv_num_q;
  logic [3:0]         dv_ovf_q;
  logic [VW-1:0]      dv_div_q;
  logic [QW-1:0]      dv_q_q;
  side_t              dv_side_q;
  logic [3:0][NW-1:0] num_d;
  logic [3:0]         ovf_d;
  logic [VW-1:0]      div_d;

  always_comb begin
    logic [DW-1:0] mag;
    div_d = {rq_q, 2'b00};
    for (int i = 0; i < 4; i++) begin
      mag      = rs_q.d[i][DW-1] ? DW'(-rs_q.d[i]) : rs_q.d[i];
      num_d[i] = (NW'(mag) << F) + (NW'(rq_q) << 1);
      ovf_d[i] = EW'(num_d[i]) >= (EW'(div_d) << W);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_num_q  <= num_d;
      dv_ovf_q  <= ovf_d;
      dv_div_q  <= div_d;
      dv_q_q    <= rq_q;
      dv_side_q <= rs_q;
    end
  end

  // restoring divider, one quotient bit per stage
  logic [3:0][NW-1:0] ds_rem_q [W];
  logic [3:0][W-1:0]  ds_quo_q [W];
  logic [VW-1:0]      ds_div_q [W];
  logic [QW-1:0]      ds_q_q   [W];
  logic [3:0]         ds_ovf_q [W];
  side_t              ds_side_q[W];

  for (genvar k = 0; k < W; k++) begin : g_div
    localparam int B = W - 1 - k;
    logic [3:0][NW-1:0] rem_in;
    logic [3:0][W-1:0]  quo_in;
    logic [VW-1:0]      div_in;
    logic [QW-1:0]      q_in;
    logic [3:0]         ovf_in;
    side_t              side_in;
    logic [EW-1:0]      cand;
    if (k == 0) begin : g_first
      assign rem_in  = dv_num_q;
      assign quo_in  = '0;
      assign div_in  = dv_div_q;
      assign q_in    = dv_q_q;
      assign ovf_in  = dv_ovf_q;
      assign side_in = dv_side_q;
    end else begin : g_next
      assign rem_in  = ds_rem_q[k-1];
      assign quo_in  = ds_quo_q[k-1];
      assign div_in  = ds_div_q[k-1];
      assign q_in    = ds_q_q[k-1];
      assign ovf_in  = ds_ovf_q[k-1];
      assign side_in = ds_side_q[k-1];
    end
    assign cand = EW'(div_in) << B;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ds_div_q[k]  <= div_in;
        ds_q_q[k]    <= q_in;
        ds_ovf_q[k]  <= ovf_in;
        ds_side_q[k] <= side_in;
        for (int i = 0; i < 4; i++) begin
          if (EW'(rem_in[i]) >= cand) begin
            ds_rem_q[k][i] <= rem_in[i] - cand[NW-1:0];
            ds_quo_q[k][i] <= {quo_in[i][W-2:0], 1'b1};
          end else begin
            ds_rem_q[k][i] <= rem_in[i];
            ds_quo_q[k][i] <= {quo_in[i][W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // saturate and pick the root lane
  conv_out_t out_q;
  conv_out_t out_d;

  always_comb begin
    logic          neg;
    logic [W-1:0]  mag;
    side_t         s;
    s        = ds_side_q[W-1];
    out_d.ok = s.ok;
    for (int i = 0; i < 4; i++) begin
      neg = s.d[i][DW-1];
      mag = ds_quo_q[W-1][i];
      if (i == int'(s.sel)) begin
        out_d.q[i] = (ds_q_q[W-1] > QW'(FLD_MAX)) ? FLD_MAX : W'(ds_q_q[W-1]);
      end else if (ds_ovf_q[W-1][i]) begin
        out_d.q[i] = neg ? FLD_MIN : FLD_MAX;
      end else if (neg) begin
        out_d.q[i] = (mag >= FLD_MIN) ? FLD_MIN : W'(-mag);
      end else begin
        out_d.q[i] = (mag > FLD_MAX) ? FLD_MAX : mag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign conv_o = out_q;

endmodule

// ----- hw/rtl/frame_to_quaternion_pair_core.sv -----
// Streams one point per cycle: each input transaction carries a surface normal
// and a curvature direction, and each output transaction carries the frame
// quaternion, the flipped-frame quaternion and a degenerate flag. A new point
// is taken every cycle unless the output is held off. The pipeline holds the 3
// front stages (products, cross product, branch select), the 16-stage
// square-root digit pipeline, 2 setup stages, the 16-stage restoring divider
// and the output stage; if the output is held off, all of them stall together.
module frame_to_quaternion_pair_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // normal_x, normal_y, normal_z, curv_x, curv_y, curv_z
  input  logic [6*f2qp_pkg::W-1:0] s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // quat_w, quat_x, quat_y, quat_z, flip_w, flip_x, flip_y, flip_z
  output logic [8*f2qp_pkg::W-1:0] m_axis_tdata_o,
  // degenerate
  output logic                    m_axis_tuser_o
);
  import f2qp_pkg::*;

  localparam int LAT = 3 + QN + 2 + W + 1;

  logic en;
  logic [LAT-1:0] vld_q;

  assign en              = !vld_q[LAT-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
    end
  end

  logic signed [W-1:0] nx, ny, nz, cx, cy, cz;
  assign nx = s_axis_tdata_i[0*W +: W];
  assign ny = s_axis_tdata_i[1*W +: W];
  assign nz = s_axis_tdata_i[2*W +: W];
  assign cx = s_axis_tdata_i[3*W +: W];
  assign cy = s_axis_tdata_i[4*W +: W];
  assign cz = s_axis_tdata_i[5*W +: W];

  // stage 1: products
  logic signed [PW-1:0] p_q [6];
  logic signed [W-1:0]  n1_q [3];
  logic signed [W-1:0]  c1_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= ny * cz;
      p_q[1] <= nz * cy;
      p_q[2] <= nz * cx;
      p_q[3] <= nx * cz;
      p_q[4] <= nx * cy;
      p_q[5] <= ny * cx;
      n1_q[0] <= nx; n1_q[1] <= ny; n1_q[2] <= nz;
      c1_q[0] <= cx; c1_q[1] <= cy; c1_q[2] <= cz;
    end
  end

  // round to nearest, ties away from zero
  function automatic logic signed [CW-1:0] rnd(input logic signed [PW:0] v);
    logic [PW:0] mag;
    logic [PW:0] r;
    mag = v[PW] ? (PW+1)'(-v) : v;
    r   = (mag + ((PW+1)'(1) << (F - 1))) >> F;
    return v[PW] ? CW'(-r) : CW'(r);
  endfunction

  // stage 2: cross product
  logic signed [CW-1:0] x2_q [3];
  logic signed [W-1:0]  n2_q [3];
  logic signed [W-1:0]  c2_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q[0] <= rnd((PW+1)'(p_q[0]) - (PW+1)'(p_q[1]));
      x2_q[1] <= rnd((PW+1)'(p_q[2]) - (PW+1)'(p_q[3]));
      x2_q[2] <= rnd((PW+1)'(p_q[4]) - (PW+1)'(p_q[5]));
      n2_q <= n1_q;
      c2_q <= c1_q;
    end
  end

  // stage 3: branch, root argument and numerators for both frames
  conv_in_t ca_q, cb_q;
  logic signed [CW-1:0] en0, en1, en2, ec0, ec1, ec2;
  assign en0 = CW'(n2_q[0]);
  assign en1 = CW'(n2_q[1]);
  assign en2 = CW'(n2_q[2]);
  assign ec0 = CW'(c2_q[0]);
  assign ec1 = CW'(c2_q[1]);
  assign ec2 = CW'(c2_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ca_q <= mk_conv(en0, ec0, x2_q[0], en1, ec1, x2_q[1], en2, ec2, x2_q[2]);
      cb_q <= mk_conv(en0, -ec0, -x2_q[0], en1, -ec1, -x2_q[1],
                      en2, -ec2, -x2_q[2]);
    end
  end

  conv_out_t qa, qb;

  f2qp_conv u_conv_a (
    .clk_i  (clk_i),
    .en_i   (en),
    .conv_i (ca_q),
    .conv_o (qa)
  );

  f2qp_conv u_conv_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .conv_i (cb_q),
    .conv_o (qb)
  );

  logic ok;
  assign ok             = qa.ok && qb.ok;
  assign m_axis_tdata_o = ok ? {qb.q, qa.q} : '0;
  assign m_axis_tuser_o = !ok;

endmodule
